>>> rtl/cbe_pkg.sv
// Package for the CBOR item head encoder: field widths, mode codes,
// additional-information codes and register map.
// No dependencies.
package cbe_pkg;

    localparam int MODE_W         = 4;
    localparam int VALUE_W        = 64;
    localparam int BYTE_W         = 8;
    localparam int OFFSET_W       = 16;
    localparam int CAP_W          = 16;
    localparam int CNT_W          = 4;
    localparam int PADDR_W        = 3;
    localparam int PDATA_W        = 32;

    localparam int POSITION_BITS_DEFAULT = 16;

    localparam logic [CAP_W-1:0] CAP_RESET = 16'hFFFF;

    // Register index (word address) of the capacity register.
    localparam logic REG_CAPACITY = 1'b0;

    // Input modes.
    localparam logic [MODE_W-1:0] MODE_UINT        = 4'd0;
    localparam logic [MODE_W-1:0] MODE_INT         = 4'd1;
    localparam logic [MODE_W-1:0] MODE_BYTES       = 4'd2;
    localparam logic [MODE_W-1:0] MODE_TEXT        = 4'd3;
    localparam logic [MODE_W-1:0] MODE_ARRAY       = 4'd4;
    localparam logic [MODE_W-1:0] MODE_MAP         = 4'd5;
    localparam logic [MODE_W-1:0] MODE_BOOL        = 4'd6;
    localparam logic [MODE_W-1:0] MODE_FLOAT       = 4'd7;
    localparam logic [MODE_W-1:0] MODE_INDEF_ARRAY = 4'd8;
    localparam logic [MODE_W-1:0] MODE_INDEF_MAP   = 4'd9;
    localparam logic [MODE_W-1:0] MODE_BREAK       = 4'd10;
    localparam logic [MODE_W-1:0] MODE_PAYLOAD     = 4'd11;

    // Major types.
    localparam logic [2:0] MAJOR_UINT   = 3'd0;
    localparam logic [2:0] MAJOR_NINT   = 3'd1;
    localparam logic [2:0] MAJOR_ARRAY  = 3'd4;
    localparam logic [2:0] MAJOR_MAP    = 3'd5;
    localparam logic [2:0] MAJOR_SIMPLE = 3'd7;

    // Additional-information codes.
    localparam logic [4:0] AI_ONE       = 5'd24;
    localparam logic [4:0] AI_TWO       = 5'd25;
    localparam logic [4:0] AI_FOUR      = 5'd26;
    localparam logic [4:0] AI_EIGHT     = 5'd27;
    localparam logic [4:0] AI_INDEF     = 5'd31;
    localparam logic [4:0] SIMPLE_FALSE = 5'd20;
    localparam logic [4:0] SIMPLE_TRUE  = 5'd21;
    localparam logic [4:0] SIMPLE_BREAK = 5'd31;

endpackage

>>> rtl/cbe_item_if.sv
// Input channel of the CBOR item head encoder: valid/ready plus mode and value.
// Depends on cbe_pkg.
interface cbe_item_if;
    import cbe_pkg::*;

    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

>>> rtl/cbe_result_if.sv
// Result channel of the CBOR item head encoder: one encoded byte per beat.
// Depends on cbe_pkg.
interface cbe_result_if;
    import cbe_pkg::*;

    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   out_byte;
    logic [OFFSET_W-1:0] byte_offset;
    logic                overflow;
    logic                last;

    modport source (output valid, output out_byte, output byte_offset, output overflow,
                    output last, input ready);
    modport sink   (input valid, input out_byte, input byte_offset, input overflow,
                    input last, output ready);
endinterface

>>> rtl/cbor_item_head_encoder_top.sv
// CBOR item head encoder. A taken item beat is held in the item register; each
// byte then passes the result register. Throughput: one result beat per cycle
// while the result port is ready; an item yields 1 to 9 beats (head plus up to
// eight argument bytes). A new item is taken in the cycle its last result is
// produced. Reset (rst_n, async, low) clears the write position to 0 and sets
// capacity to 65535; no clearing pass.
module cbor_item_head_encoder_top #(
    parameter int POSITION_BITS = cbe_pkg::POSITION_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    cbe_item_if.sink                      item,
    cbe_result_if.source                  result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cbe_pkg::PADDR_W-1:0]   paddr,
    input  logic [cbe_pkg::PDATA_W-1:0]   pwdata,
    output logic [cbe_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import cbe_pkg::*;

    // Comparisons are done at a width that holds the position plus up to
    // eight argument bytes and the full capacity without wrapping.
    localparam int CMP_W = ((POSITION_BITS > CAP_W) ? POSITION_BITS : CAP_W) + 1;

    // The item register walks through the head byte, the argument check (which
    // also emits the first argument byte), and the remaining argument bytes.
    typedef enum logic [1:0] {
        PH_HEAD,
        PH_CHECK,
        PH_ARG
    } phase_t;

    // ------------------------------------------------------------------
    // Configuration port. Writes complete in the access cycle; the word
    // index is taken from paddr above the byte lane bits.
    // ------------------------------------------------------------------
    logic [CAP_W-1:0] cap_reg;
    logic [CAP_W-1:0] cap_next;
    logic             cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);
    assign cap_next  = cfg_write ? pwdata[CAP_W-1:0] : cap_reg;
    assign prdata    = (paddr[2] == REG_CAPACITY) ? {{(PDATA_W-CAP_W){1'b0}}, cap_reg}
                                                  : '0;

    // ------------------------------------------------------------------
    // Decode of the incoming beat into head byte, left-aligned argument and
    // argument byte count. This is all the per-item arithmetic there is.
    // ------------------------------------------------------------------
    logic [2:0]         dec_major;
    logic [VALUE_W-1:0] dec_typed_arg;
    logic               dec_typed;
    logic               dec_ok;
    logic [BYTE_W-1:0]  dec_head;
    logic [VALUE_W-1:0] dec_arg;
    logic [CNT_W-1:0]   dec_cnt;
    logic [VALUE_W-1:0] dec_aligned;

    always_comb
    begin
        dec_major     = MAJOR_UINT;
        dec_typed_arg = item.value;
        dec_typed     = 1'b0;
        dec_ok        = 1'b1;
        dec_head      = '0;
        dec_arg       = '0;
        dec_cnt       = '0;

        unique case (item.mode)
            MODE_UINT:
            begin
                dec_typed = 1'b1;
            end
            MODE_INT:
            begin
                dec_typed = 1'b1;
                // Negative values encode the one's complement under major type 1.
                if (item.value[VALUE_W-1])
                begin
                    dec_major     = MAJOR_NINT;
                    dec_typed_arg = ~item.value;
                end
            end
            MODE_BYTES, MODE_TEXT, MODE_ARRAY, MODE_MAP:
            begin
                dec_typed = 1'b1;
                dec_major = item.mode[2:0];
            end
            MODE_BOOL:
            begin
                dec_head = {MAJOR_SIMPLE,
                            (item.value != '0) ? SIMPLE_TRUE : SIMPLE_FALSE};
            end
            MODE_FLOAT:
            begin
                dec_head = {MAJOR_SIMPLE, AI_FOUR};
                dec_arg  = {32'b0, item.value[31:0]};
                dec_cnt  = CNT_W'(4);
            end
            MODE_INDEF_ARRAY:
            begin
                dec_head = {MAJOR_ARRAY, AI_INDEF};
            end
            MODE_INDEF_MAP:
            begin
                dec_head = {MAJOR_MAP, AI_INDEF};
            end
            MODE_BREAK:
            begin
                dec_head = {MAJOR_SIMPLE, SIMPLE_BREAK};
            end
            MODE_PAYLOAD:
            begin
                dec_head = item.value[BYTE_W-1:0];
            end
            default:
            begin
                // Undefined modes are taken and dropped without a result.
                dec_ok = 1'b0;
            end
        endcase

        // Shortest form of the argument for the typed items.
        if (dec_typed)
        begin
            dec_arg = dec_typed_arg;
            priority if (dec_typed_arg < VALUE_W'(AI_ONE))
            begin
                dec_head = {dec_major, dec_typed_arg[4:0]};
                dec_cnt  = '0;
            end
            else if (dec_typed_arg[VALUE_W-1:8] == '0)
            begin
                dec_head = {dec_major, AI_ONE};
                dec_cnt  = CNT_W'(1);
            end
            else if (dec_typed_arg[VALUE_W-1:16] == '0)
            begin
                dec_head = {dec_major, AI_TWO};
                dec_cnt  = CNT_W'(2);
            end
            else if (dec_typed_arg[VALUE_W-1:32] == '0)
            begin
                dec_head = {dec_major, AI_FOUR};
                dec_cnt  = CNT_W'(4);
            end
            else
            begin
                dec_head = {dec_major, AI_EIGHT};
                dec_cnt  = CNT_W'(8);
            end
        end
    end

    // Left-align the argument so its first (most significant) byte sits at
    // the top; each emitted byte then shifts the register left by one byte.
    always_comb
    begin
        unique case (dec_cnt)
            CNT_W'(1): dec_aligned = {dec_arg[7:0], 56'b0};
            CNT_W'(2): dec_aligned = {dec_arg[15:0], 48'b0};
            CNT_W'(4): dec_aligned = {dec_arg[31:0], 32'b0};
            CNT_W'(8): dec_aligned = dec_arg;
            default:   dec_aligned = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Item register and byte generator.
    // ------------------------------------------------------------------
    logic                     item_valid_reg;
    logic                     item_valid_next;
    phase_t                   phase_reg;
    phase_t                   phase_next;
    logic [BYTE_W-1:0]        head_reg;
    logic [VALUE_W-1:0]       arg_reg;
    logic [VALUE_W-1:0]       arg_next;
    logic [CNT_W-1:0]         cnt_reg;
    logic [CNT_W-1:0]         cnt_next;
    logic [POSITION_BITS-1:0] pos_reg;
    logic [POSITION_BITS-1:0] pos_next;

    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [BYTE_W-1:0]        out_byte_reg;
    logic [OFFSET_W-1:0]      out_offset_reg;
    logic                     out_ovf_reg;
    logic                     out_last_reg;

    logic                     item_load;
    logic                     gen;
    logic                     done;
    logic [BYTE_W-1:0]        r_byte;
    logic                     r_ovf;
    logic                     r_last;
    logic                     advance;
    logic [CMP_W-1:0]         pos_ext;
    logic [CMP_W-1:0]         cap_ext;

    assign pos_ext = CMP_W'(pos_reg);
    assign cap_ext = CMP_W'(cap_reg);

    // A result is produced whenever the result register is free or draining.
    assign gen        = item_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !item_valid_reg || (gen && done);
    assign item_load  = item.valid && item.ready;

    always_comb
    begin
        r_byte     = '0;
        r_ovf      = 1'b0;
        r_last     = 1'b0;
        done       = 1'b0;
        advance    = 1'b0;
        phase_next = phase_reg;
        arg_next   = arg_reg;
        cnt_next   = cnt_reg;

        unique case (phase_reg)
            PH_HEAD:
            begin
                if (pos_ext >= cap_ext)
                begin
                    r_ovf  = 1'b1;
                    r_last = 1'b1;
                    done   = 1'b1;
                end
                else
                begin
                    r_byte     = head_reg;
                    r_last     = (cnt_reg == '0);
                    done       = (cnt_reg == '0);
                    advance    = 1'b1;
                    phase_next = PH_CHECK;
                end
            end
            PH_CHECK:
            begin
                // All argument bytes must fit, or none is placed.
                if ((pos_ext + CMP_W'(cnt_reg)) > cap_ext)
                begin
                    r_ovf  = 1'b1;
                    r_last = 1'b1;
                    done   = 1'b1;
                end
                else
                begin
                    r_byte     = arg_reg[VALUE_W-1 -: BYTE_W];
                    r_last     = (cnt_reg == CNT_W'(1));
                    done       = (cnt_reg == CNT_W'(1));
                    advance    = 1'b1;
                    arg_next   = {arg_reg[VALUE_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
                    cnt_next   = cnt_reg - CNT_W'(1);
                    phase_next = PH_ARG;
                end
            end
            PH_ARG:
            begin
                r_byte   = arg_reg[VALUE_W-1 -: BYTE_W];
                r_last   = (cnt_reg == CNT_W'(1));
                done     = (cnt_reg == CNT_W'(1));
                advance  = 1'b1;
                arg_next = {arg_reg[VALUE_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
                cnt_next = cnt_reg - CNT_W'(1);
            end
            default:
            begin
                done = 1'b1;
            end
        endcase

        if (!gen)
        begin
            phase_next = phase_reg;
            arg_next   = arg_reg;
            cnt_next   = cnt_reg;
        end
        if (item_load)
        begin
            phase_next = PH_HEAD;
            arg_next   = dec_aligned;
            cnt_next   = dec_cnt;
        end
    end

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (gen && done)
        begin
            item_valid_next = 1'b0;
        end
        if (item_load && dec_ok)
        begin
            item_valid_next = 1'b1;
        end

        pos_next = pos_reg;
        if (gen && advance)
        begin
            pos_next = pos_reg + POSITION_BITS'(1);
        end

        out_valid_next = out_valid_reg;
        if (gen)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // State, item payload and the registered result beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg        <= CAP_RESET;
            pos_reg        <= '0;
            item_valid_reg <= 1'b0;
            phase_reg      <= PH_HEAD;
            out_valid_reg  <= 1'b0;
            head_reg       <= '0;
            arg_reg        <= '0;
            cnt_reg        <= '0;
            out_byte_reg   <= '0;
            out_offset_reg <= '0;
            out_ovf_reg    <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            cap_reg        <= cap_next;
            pos_reg        <= pos_next;
            item_valid_reg <= item_valid_next;
            phase_reg      <= phase_next;
            out_valid_reg  <= out_valid_next;
            if (item_load)
            begin
                head_reg <= dec_head;
            end
            arg_reg <= arg_next;
            cnt_reg <= cnt_next;
            if (gen)
            begin
                out_byte_reg   <= r_byte;
                out_offset_reg <= OFFSET_W'(pos_reg);
                out_ovf_reg    <= r_ovf;
                out_last_reg   <= r_last;
            end
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.out_byte    = out_byte_reg;
    assign result.byte_offset = out_offset_reg;
    assign result.overflow    = out_ovf_reg;
    assign result.last        = out_last_reg;

endmodule
